>>> src/b64e_pkg.sv
// Shared types, constants and the character lookup for the base64 stream encoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

  // Characters per queued entry, and the width of the per-entry count (1 to 4).
  localparam int unsigned MaxChars   = 4;
  localparam int unsigned CountWidth = 3;

  // A queued code is a 6-bit symbol index, or the pad marker in bit 6.
  localparam logic [6:0] PAD_CODE  = 7'h40;
  localparam logic [7:0] PAD_ASCII = 8'h3D;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [CountWidth-1:0]       count;
    logic [MaxChars-1:0][6:0]    codes;
    logic                        fin;
  } b64e_entry_t;

  // Symbol index or pad marker to its ASCII character.
  function automatic logic [7:0] b64e_char(input logic [6:0] code);
    logic [5:0] v;
    logic [7:0] ch;
    v = code[5:0];
    if (code[6]) begin
      ch = PAD_ASCII;
    end else if (v < 6'd26) begin
      ch = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      ch = 8'h61 + {2'b00, v - 6'd26};
    end else if (v < 6'd62) begin
      ch = 8'h30 + {2'b00, v - 6'd52};
    end else if (v == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> src/base64_stream_encoder_core.sv
// Top level of the padded base64 stream encoder.
// Instantiates b64e_front, b64e_queue and b64e_back; uses b64e_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one message byte per beat in
//   data_byte, with final_byte set on the last byte of a message.
//   Output channel (out_valid/out_ready) carries one ASCII character per beat
//   in out_char; run_last marks the last character caused by an input byte and
//   message_end the last character of the message, padding included.
//   With the emitter idle, the first character of a byte passes in turn
//   through its queue entry, the emitter's current entry and the output
//   register. The emitter registers one character per cycle while the
//   receiver takes them. An inner byte yields one or two characters and a
//   final byte up to four, about four characters per three bytes over a
//   long message. The front end takes a byte every cycle while the entry
//   queue (QUEUE_DEPTH entries) has room.
//   When the receiver stalls, the output beat holds, the queue fills and
//   in_ready falls once it is full.
//   Reset clears the group phase, leftover bits, queue and output valid; the
//   block accepts bytes in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder_core #(
  parameter int unsigned QUEUE_DEPTH = b64e_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       final_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_char,
  output logic            run_last,
  output logic            message_end
);
  import b64e_pkg::*;

  b64e_entry_t push_entry;
  b64e_entry_t head_entry;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;

  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_entry  (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_entry  (head_entry)
  );

  b64e_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_entry     (head_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .run_last    (run_last),
    .message_end (message_end)
  );

endmodule

`default_nettype wire

>>> src/b64e_front.sv
// Front end: takes message bytes, keeps the group phase and leftover bits,
// and builds one queue entry of symbol codes per byte. Uses b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_front (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           data_byte,
  input  wire logic                 final_byte,
  input  wire logic                 q_full,
  output logic                      q_push,
  output b64e_pkg::b64e_entry_t     q_entry
);
  import b64e_pkg::*;

  logic [1:0] group_phase;
  logic [1:0] group_phase_next;
  logic [3:0] carry_bits;
  logic [3:0] carry_bits_next;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_entry          = '0;
    q_entry.fin      = final_byte;
    group_phase_next = group_phase;
    carry_bits_next  = carry_bits;
    unique case (group_phase)
      2'd1: begin
        q_entry.codes[0] = {1'b0, carry_bits[1:0], data_byte[7:4]};
        q_entry.count    = CountWidth'(1);
        if (final_byte) begin
          q_entry.codes[1] = {1'b0, data_byte[3:0], 2'b00};
          q_entry.codes[2] = PAD_CODE;
          q_entry.count    = CountWidth'(3);
        end
        carry_bits_next  = data_byte[3:0];
        group_phase_next = 2'd2;
      end
      2'd2: begin
        q_entry.codes[0] = {1'b0, carry_bits, data_byte[7:6]};
        q_entry.codes[1] = {1'b0, data_byte[5:0]};
        q_entry.count    = CountWidth'(2);
        carry_bits_next  = 4'd0;
        group_phase_next = 2'd0;
      end
      default: begin
        // Phase three cannot occur; it is handled as the start of a group.
        q_entry.codes[0] = {1'b0, data_byte[7:2]};
        q_entry.count    = CountWidth'(1);
        if (final_byte) begin
          q_entry.codes[1] = {1'b0, data_byte[1:0], 4'd0};
          q_entry.codes[2] = PAD_CODE;
          q_entry.codes[3] = PAD_CODE;
          q_entry.count    = CountWidth'(4);
        end
        carry_bits_next  = {2'b00, data_byte[1:0]};
        group_phase_next = 2'd1;
      end
    endcase
    if (final_byte) begin
      carry_bits_next  = 4'd0;
      group_phase_next = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_phase <= 2'd0;
      carry_bits  <= 4'd0;
    end else if (q_push) begin
      group_phase <= group_phase_next;
      carry_bits  <= carry_bits_next;
    end
  end

endmodule

`default_nettype wire

>>> src/b64e_queue.sv
// Short queue of decoded entries between the front end and the character emitter.
// Uses b64e_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none

module b64e_queue #(
  parameter int unsigned DEPTH = b64e_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire b64e_pkg::b64e_entry_t wr_entry,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       not_empty,
  output b64e_pkg::b64e_entry_t      rd_entry
);
  import b64e_pkg::*;

  localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntWidth = $clog2(DEPTH + 1);

  b64e_entry_t         slots [DEPTH];
  logic [PtrWidth-1:0] wr_ptr;
  logic [PtrWidth-1:0] rd_ptr;
  logic [CntWidth-1:0] fill;

  assign full      = (fill == CntWidth'(DEPTH));
  assign not_empty = (fill != '0);
  assign rd_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CntWidth'(DEPTH))
    else $error("queue fill count beyond depth");
  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

>>> src/b64e_back.sv
// Back end: walks each queued entry one character per cycle, unless the output stalls,
// into a registered output beat with the run and message flags. Uses b64e_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64e_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  q_not_empty,
  input  wire b64e_pkg::b64e_entry_t q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [7:0]                 out_char,
  output logic                       run_last,
  output logic                       message_end
);
  import b64e_pkg::*;

  b64e_entry_t cur;
  logic        busy;
  logic [1:0]  idx;
  logic        advance;
  logic        cur_last;

  // The output register can take a new character when empty or being drained.
  assign advance  = busy && (!out_valid || out_ready);
  assign cur_last = (idx == 2'(cur.count - 1'b1));
  // Load the next entry when idle, or as the current one hands over its last character.
  assign q_pop    = q_not_empty && (!busy || (advance && cur_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !advance) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        out_valid   <= 1'b1;
        out_char    <= b64e_char(cur.codes[idx]);
        run_last    <= cur_last;
        message_end <= cur_last && cur.fin;
      end
      if (q_pop) begin
        cur  <= q_entry;
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (advance) begin
        idx <= idx + 1'b1;
        if (cur_last) begin
          busy <= 1'b0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> ({1'b0, idx} < cur.count))
    else $error("character index past entry length");
  a_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && message_end) |-> run_last)
    else $error("message end without run end");
`endif

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for base64_stream_encoder_core: random byte messages with
// bursty input and stalling output, checked against an in-bench padded base64 encoder.
// Depends on b64e_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module testbench;
  import b64e_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned HoldCycles = 400;
  localparam bit [511:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] data;
    logic       fin;
    logic       drain;
  } msg_byte_t;

  typedef struct {
    logic [7:0] ch;
    logic       run_last;
    logic       msg_end;
  } b64_char_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       final_byte = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       run_last;
  logic       message_end;

  base64_stream_encoder_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .final_byte  (final_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .run_last    (run_last),
    .message_end (message_end)
  );

  always #5 clk = ~clk;

  msg_byte_t byte_queue[$];
  b64_char_t expected_chars[$];

  // Encoder state as the testbench sees it.
  logic [1:0] enc_phase = 2'd0;
  logic [3:0] enc_carry = 4'd0;

  int errors = 0;
  int bytes_sent = 0;
  int msgs_sent = 0;
  int chars_seen = 0;
  int pads_seen = 0;
  int long_holds = 0;
  int drain_pauses = 0;

  function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
    return Alphabet[8 * (63 - idx) +: 8];
  endfunction

  // Works out the characters one accepted byte causes and queues them.
  function automatic void encode_byte(input logic [7:0] b, input logic fin);
    logic [7:0] chars [4];
    int         n;
    b64_char_t  c;
    n = 0;
    case (enc_phase)
      2'd1: begin
        chars[0]  = b64_symbol({enc_carry[1:0], b[7:4]});
        enc_carry = b[3:0];
        enc_phase = 2'd2;
        n = 1;
        if (fin) begin
          chars[1] = b64_symbol({b[3:0], 2'b00});
          chars[2] = PAD_ASCII;
          n = 3;
        end
      end
      2'd2: begin
        chars[0]  = b64_symbol({enc_carry, b[7:6]});
        chars[1]  = b64_symbol(b[5:0]);
        enc_carry = 4'd0;
        enc_phase = 2'd0;
        n = 2;
      end
      default: begin
        // A phase of three behaves as the start of a group.
        chars[0]  = b64_symbol(b[7:2]);
        enc_carry = {2'b00, b[1:0]};
        enc_phase = 2'd1;
        n = 1;
        if (fin) begin
          chars[1] = b64_symbol({b[1:0], 4'b0000});
          chars[2] = PAD_ASCII;
          chars[3] = PAD_ASCII;
          n = 4;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      c.ch       = chars[i];
      c.run_last = (i == n - 1);
      c.msg_end  = (i == n - 1) && fin;
      expected_chars.push_back(c);
    end
    if (fin) begin
      enc_phase = 2'd0;
      enc_carry = 4'd0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 50) $display("mismatch at char %0d: %s", chars_seen, msg);
  endtask

  task automatic push_byte(input logic [7:0] data, input logic fin, input logic drain);
    msg_byte_t m;
    m.data  = data;
    m.fin   = fin;
    m.drain = drain;
    byte_queue.push_back(m);
  endtask

  // Driver: bursts of beats with random gaps; a byte marked drain waits for an empty
  // expectation queue before it is offered.
  int        burst_left = 1;
  int        gap_left = 0;
  logic      offer;
  logic      load;
  msg_byte_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      data_byte  <= 8'h00;
      final_byte <= 1'b0;
    end else begin
      offer = in_valid;
      load  = 1'b0;
      if (in_valid && in_ready) begin
        encode_byte(data_byte, final_byte);
        bytes_sent++;
        if (final_byte) msgs_sent++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (byte_queue.size() != 0) begin
          if (byte_queue[0].drain && expected_chars.size() != 0) begin
            // Hold the next message back until the encoder has drained.
          end else begin
            next_item = byte_queue.pop_front();
            if (next_item.drain) drain_pauses++;
            offer = 1'b1;
            load  = 1'b1;
            if (burst_left <= 1) begin
              burst_left = $urandom_range(1, 24);
              gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            end else begin
              burst_left--;
            end
          end
        end
      end
      in_valid <= offer;
      if (load) begin
        data_byte  <= next_item.data;
        final_byte <= next_item.fin;
      end
    end
  end

  // Monitor: checks each output beat and drives out_ready from a pattern that changes
  // stall density every stretch, with two long hold-offs.
  int   stretch_left = 0;
  int   stall_pct = 0;
  int   hold_left = 0;
  logic ready_next;
  b64_char_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected beat, char 'h%02h", out_char));
        end else begin
          want = expected_chars.pop_front();
          if (out_char !== want.ch)
            report_mismatch($sformatf("out_char 'h%02h, want 'h%02h", out_char, want.ch));
          if (run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, want %b", run_last, want.run_last));
          if (message_end !== want.msg_end)
            report_mismatch($sformatf("message_end %b, want %b", message_end, want.msg_end));
        end
        if (out_char == PAD_ASCII) pads_seen++;
        chars_seen++;
        if (chars_seen == 150 || chars_seen == 500) begin
          hold_left = HoldCycles;
          long_holds++;
        end
      end
      if (stretch_left == 0) begin
        stretch_left = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        stretch_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = ($urandom_range(0, 99) >= stall_pct);
      end
      out_ready <= ready_next;
    end
  end

  // Watchdog on cycles without any beat on either channel.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IdleLimit) begin
      $display("timeout after %0d idle cycles, %0d chars pending",
               IdleLimit, expected_chars.size());
      $display("testbench: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int len;
    logic drain;

    // Directed messages: one-byte and two-byte tails, a final byte that closes a
    // group, both ends of the alphabet and a familiar text sample.
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hFB, 1'b0, 1'b0);
    push_byte(8'hEF, 1'b0, 1'b0);
    push_byte(8'hBE, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'h4D, 1'b0, 1'b0);
    push_byte(8'h61, 1'b0, 1'b0);
    push_byte(8'h6E, 1'b1, 1'b0);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'h02, 1'b0, 1'b0);
    push_byte(8'h03, 1'b0, 1'b0);
    push_byte(8'h80, 1'b1, 1'b0);

    // Random messages, mostly short, some long; a few wait for a drained encoder.
    while (byte_queue.size() < 430) begin
      len   = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      drain = (byte_queue.size() == 20) || ($urandom_range(0, 11) == 0);
      for (int i = 0; i < len; i++)
        push_byte(8'($urandom_range(0, 255)), i == len - 1, drain && i == 0);
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);

    $display("covered %0d bytes in %0d messages, %0d characters (%0d pads)",
             bytes_sent, msgs_sent, chars_seen, pads_seen);
    $display("with %0d long output hold-offs and %0d drained restarts",
             long_holds, drain_pauses);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
